FILE: src/sasp_pkg.sv
// ----------------------------------------------------------------------------
// sasp_pkg
// shared types and codes for the six-axis serial packet decoder
// ----------------------------------------------------------------------------
package sasp_pkg;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_ESC   = 8'h5E;  // '^'
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_Q     = 8'h51;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] TYPE_RESET = 8'h40;  // '@'
  localparam logic [7:0] TYPE_AXES  = 8'h44;  // 'D'
  localparam logic [7:0] TYPE_BTN   = 8'h2E;  // '.'
  localparam logic [7:0] TYPE_ERR   = 8'h3F;  // '?'
  localparam logic [7:0] TYPE_K     = 8'h4B;
  localparam logic [7:0] TYPE_A     = 8'h41;
  localparam logic [7:0] TYPE_B     = 8'h42;
  localparam logic [7:0] TYPE_H     = 8'h48;
  localparam logic [7:0] TYPE_S     = 8'h53;
  localparam logic [7:0] TYPE_Y     = 8'h59;
  localparam logic [7:0] TYPE_QUOTE = 8'h22;
  localparam logic [7:0] TYPE_P     = 8'h50;

  localparam int unsigned KEPT_BYTES = 16;
  localparam logic [7:0]  AXES_LEN   = 8'd16;
  localparam logic [7:0]  BTN_LEN    = 8'd4;
  localparam logic [7:0]  P_LEN      = 8'd3;
  localparam logic [7:0]  BTN_MASK   = 8'hBF;

  localparam logic [2:0] ST_AXES    = 3'd0;
  localparam logic [2:0] ST_BUTTONS = 3'd1;
  localparam logic [2:0] ST_RESET   = 3'd2;
  localparam logic [2:0] ST_ERROR   = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_UNKNOWN = 3'd5;
  localparam logic [2:0] ST_BAD     = 3'd6;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_AXES  = 2'd1;
  localparam logic [1:0] ACT_BTN   = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam int unsigned OUT_BITS = 112;

  typedef struct packed {
    logic [2:0]        status;
    logic [1:0]        action;
    logic [5:0][15:0]  axes;
    logic [11:0]       buttons;
  } cmd_t;

endpackage

FILE: src/six_axis_serial_packet_decoder.sv
// ----------------------------------------------------------------------------
// six_axis_serial_packet_decoder
// serial packet decoder for a six-axis controller
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one received serial byte per beat. packets end at an
//   unescaped carriage return; '^' escapes the following byte.
//   m_axis gives one result beat per terminator: status, the six current
//   axes and the twelve button bits. other bytes give no beat.
//   cfg_valid/cfg_data writes reports_enabled; cfg_ready is always high and
//   the register is meant to be written only while the block is idle.
// flow:
//   one byte per cycle while the queue is not full. the intake classifies a
//   packet in the cycle its terminator is taken and pushes one command into a
//   two-entry queue; the result stage turns it into an output beat, so the
//   queue entry and the output register lie between a terminator and its result.
// reset and stall:
//   rst clears the packet count, escape state, axes, buttons and queue, and
//   sets reports_enabled to 1. a stalled m_axis holds its beat; the queue
//   takes up to two more terminators, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module six_axis_serial_packet_decoder #(
  parameter int unsigned MAX_PACKET_LENGTH = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  // serial bytes in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] rx_byte
  // results out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] packet_status, [18:3] axis_tx, [34:19] axis_ty, [50:35] axis_tz,
  // [66:51] axis_rx, [82:67] axis_ry, [98:83] axis_rz, [110:99] button_state,
  // [111] zero
  output logic [sasp_pkg::OUT_BITS-1:0]   m_axis_tdata,
  // configuration: reports_enabled
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_data
);
  import sasp_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  logic pop;
  cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  // intake: escape tracking, packet store and classification at the terminator
  sasp_front #(
    .MAX_PACKET_LENGTH (MAX_PACKET_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  // decouples intake from a stalled output
  sasp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .pop      (pop),
    .q_cmd    (q_cmd)
  );

  // axis and button store plus the output register
  sasp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

FILE: src/sasp_front.sv
// ----------------------------------------------------------------------------
// sasp_front
// byte intake: escape handling, packet store and packet classification
// ----------------------------------------------------------------------------
module sasp_front #(
  parameter int unsigned MAX_PACKET_LENGTH = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                cfg_valid,
  input  logic                cfg_data,
  output logic                push,
  output sasp_pkg::cmd_t      push_cmd,
  input  logic                q_full
);
  import sasp_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PACKET_LENGTH);

  logic [7:0] packet_bytes [KEPT_BYTES];
  logic [7:0] byte_count;
  logic       escape_pending;
  logic       escape_was_stored;
  logic       reports_enabled;

  logic       accept;
  logic       stored;
  logic       esc_fix;
  logic [7:0] n_len;
  logic [7:0] ptype;
  logic [15:0] btn_raw;
  cmd_t       cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign stored   = byte_count < MAX_LEN;
  assign esc_fix  = (in_byte == CHAR_M || in_byte == CHAR_Q || in_byte == CHAR_S) &&
                    escape_was_stored && byte_count >= 8'd1 &&
                    (byte_count - 8'd1) < 8'(KEPT_BYTES);

  assign push     = accept && !escape_pending && in_byte == CHAR_CR;
  assign push_cmd = cmd;

  // length as seen by the decode, terminator included
  assign n_len = stored ? byte_count + 8'd1 : byte_count;
  assign ptype = (byte_count == 8'd0) ? in_byte : packet_bytes[0];
  assign btn_raw = {packet_bytes[1] & BTN_MASK, packet_bytes[2] & BTN_MASK};

  always_comb begin
    cmd.action  = ACT_NONE;
    cmd.status  = ST_UNKNOWN;
    cmd.buttons = {btn_raw[12:7], btn_raw[5:0]};
    for (int i = 0; i < 6; i++) begin
      cmd.axes[i] = {packet_bytes[3 + 2 * i], packet_bytes[4 + 2 * i]};
    end
    if (n_len < 8'd2) begin
      cmd.status = ST_IGNORED;
    end else begin
      case (ptype)
        TYPE_RESET: begin
          cmd.status = ST_RESET;
          cmd.action = ACT_CLEAR;
        end
        TYPE_AXES: begin
          if (n_len == AXES_LEN && reports_enabled) begin
            cmd.status = ST_AXES;
            cmd.action = ACT_AXES;
          end else begin
            cmd.status = ST_BAD;
          end
        end
        TYPE_BTN: begin
          if (n_len == BTN_LEN && reports_enabled) begin
            cmd.status = ST_BUTTONS;
            cmd.action = ACT_BTN;
          end else begin
            cmd.status = ST_BAD;
          end
        end
        TYPE_ERR: cmd.status = ST_ERROR;
        TYPE_K, TYPE_A, TYPE_B, TYPE_H, TYPE_S, TYPE_Y, TYPE_QUOTE: begin
          cmd.status = ST_IGNORED;
        end
        TYPE_P: cmd.status = (n_len == P_LEN) ? ST_IGNORED : ST_BAD;
        default: cmd.status = ST_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count        <= '0;
      escape_pending    <= 1'b0;
      escape_was_stored <= 1'b0;
      reports_enabled   <= 1'b1;
    end else begin
      if (cfg_valid) begin
        reports_enabled <= cfg_data;
      end
      if (accept) begin
        if (escape_pending) begin
          escape_pending    <= 1'b0;
          escape_was_stored <= 1'b0;
        end else begin
          if (in_byte == CHAR_CR) begin
            byte_count <= '0;
          end else if (stored) begin
            byte_count <= byte_count + 8'd1;
          end
          if (in_byte == CHAR_ESC) begin
            escape_pending    <= 1'b1;
            escape_was_stored <= stored;
          end
        end
      end
    end
  end

  // packet store, no reset: every decoded entry is written by its own packet
  always_ff @(posedge clk) begin
    if (accept) begin
      if (escape_pending) begin
        if (esc_fix) begin
          packet_bytes[4'(byte_count - 8'd1)] <= CHAR_CR;
        end
      end else if (stored && byte_count < 8'(KEPT_BYTES)) begin
        packet_bytes[byte_count[3:0]] <= in_byte;
      end
    end
  end

endmodule

FILE: src/sasp_queue.sv
// ----------------------------------------------------------------------------
// sasp_queue
// two-entry command queue between intake and result stage
// ----------------------------------------------------------------------------
module sasp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  sasp_pkg::cmd_t  push_cmd,
  output logic            full,
  output logic            q_valid,
  input  logic            pop,
  output sasp_pkg::cmd_t  q_cmd
);
  import sasp_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full    = fill == 2'd2;
  assign q_valid = fill != 2'd0;
  assign q_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

FILE: src/sasp_back.sv
// ----------------------------------------------------------------------------
// sasp_back
// result stage: applies commands to the axis and button store, output register
// ----------------------------------------------------------------------------
module sasp_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  sasp_pkg::cmd_t                    q_cmd,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sasp_pkg::OUT_BITS-1:0]     out_data
);
  import sasp_pkg::*;

  logic [5:0][15:0] axis_store;
  logic [11:0]      button_store;
  logic [5:0][15:0] axis_next;
  logic [11:0]      button_next;

  assign pop = q_valid && (!out_valid || out_ready);

  always_comb begin
    axis_next   = axis_store;
    button_next = button_store;
    case (q_cmd.action)
      ACT_AXES:  axis_next = q_cmd.axes;
      ACT_BTN:   button_next = q_cmd.buttons;
      ACT_CLEAR: begin
        axis_next   = '0;
        button_next = '0;
      end
      default: begin
        axis_next   = axis_store;
        button_next = button_store;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      axis_store   <= '0;
      button_store <= '0;
    end else begin
      if (pop) begin
        out_valid    <= 1'b1;
        axis_store   <= axis_next;
        button_store <= button_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= {1'b0, button_next, axis_next, q_cmd.status};
    end
  end

endmodule

FILE: tb/tb_six_axis_serial_packet_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_six_axis_serial_packet_decoder
// self-checking bench for the six-axis serial packet decoder
// ----------------------------------------------------------------------------
// serial bytes are built as whole packets (axes, buttons, clear, error,
// replies, unknown types, bad lengths, over-long packets, escapes) plus raw
// noise, queued, and sent by a clocked driver with random gaps. a bit-exact
// predictor follows every accepted byte and queues the expected result for
// each terminator; a clocked monitor checks every result beat field by field
// while the result side stalls at random. reports_enabled is switched
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_six_axis_serial_packet_decoder;
  import sasp_pkg::*;

  localparam int unsigned MAX_LEN        = 128;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 80;
  // margin after the last result beat before the next phase
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned MAX_REPORTED   = 10;

  // one expected result beat
  typedef struct packed {
    logic [2:0]       status;
    logic [5:0][15:0] axes;     // [0] tx .. [5] rz
    logic [11:0]      buttons;
  } report_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_BITS-1:0]  m_axis_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;

  six_axis_serial_packet_decoder #(
    .MAX_PACKET_LENGTH(MAX_LEN)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // predictor state: packet gathering, escape tracking, axes and buttons
  // --------------------------------------------------------------------------
  logic [7:0]       pkt_store [KEPT_BYTES] = '{default: '0};
  logic [7:0]       pkt_len     = '0;
  logic             esc_pending = 1'b0;
  logic             esc_counted = 1'b0;   // the pending '^' went into the packet
  logic [5:0][15:0] axis_val    = '0;
  logic [11:0]      button_val  = '0;
  logic             reports_on  = 1'b1;

  report_t pending_reports [$];   // results still owed by the block
  logic [7:0] serial_q [$];       // bytes waiting for the driver

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned mismatches   = 0;

  string axis_name [6] = '{"axis_tx", "axis_ty", "axis_tz",
                           "axis_rx", "axis_ry", "axis_rz"};

  // decode a finished packet, applying it to the axes and buttons
  function automatic logic [2:0] classify_packet();
    logic [15:0] raw;
    if (pkt_len < 2) return ST_IGNORED;
    case (pkt_store[0])
      TYPE_RESET: begin
        // clears even while reports are off
        axis_val   = '0;
        button_val = '0;
        return ST_RESET;
      end
      TYPE_AXES: begin
        if (pkt_len != AXES_LEN || !reports_on) return ST_BAD;
        for (int i = 0; i < 6; i++)
          axis_val[i] = {pkt_store[3 + 2 * i], pkt_store[4 + 2 * i]};
        return ST_AXES;
      end
      TYPE_BTN: begin
        if (pkt_len != BTN_LEN || !reports_on) return ST_BAD;
        raw = {pkt_store[1] & BTN_MASK, pkt_store[2] & BTN_MASK};
        // bit 6 and bits 15:13 of the raw word are dropped, bits 12:7 close the gap
        button_val = {raw[12:7], raw[5:0]};
        return ST_BUTTONS;
      end
      TYPE_ERR: return ST_ERROR;
      TYPE_K, TYPE_A, TYPE_B, TYPE_H, TYPE_S, TYPE_Y, TYPE_QUOTE: return ST_IGNORED;
      TYPE_P: return (pkt_len == P_LEN) ? ST_IGNORED : ST_BAD;
      default: return ST_UNKNOWN;
    endcase
  endfunction

  // follow one accepted serial byte
  task automatic absorb_byte(input logic [7:0] c);
    logic    counted;
    report_t r;
    if (esc_pending) begin
      // escaped byte: never stored, never a terminator
      esc_pending = 1'b0;
      if ((c == CHAR_M || c == CHAR_Q || c == CHAR_S) && esc_counted &&
          pkt_len >= 1 && pkt_len <= KEPT_BYTES)
        pkt_store[pkt_len - 1] = CHAR_CR;
      esc_counted = 1'b0;
      return;
    end
    // count saturates, only the head of the packet is kept
    counted = (pkt_len < MAX_LEN);
    if (counted) begin
      if (pkt_len < KEPT_BYTES) pkt_store[pkt_len] = c;
      pkt_len = pkt_len + 8'd1;
    end
    if (c == CHAR_CR) begin
      r.status  = classify_packet();
      r.axes    = axis_val;
      r.buttons = button_val;
      pending_reports.push_back(r);
      pkt_len = '0;
    end else if (c == CHAR_ESC) begin
      esc_pending = 1'b1;
      esc_counted = counted;
    end
  endtask

  // --------------------------------------------------------------------------
  // idling
  // --------------------------------------------------------------------------
  bit sender_steady   = 1'b0;   // no gaps between bytes
  bit receiver_steady = 1'b0;   // no stalls on the result side
  int unsigned hold_req = 0;    // bumped to ask for one long result hold-off

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // --------------------------------------------------------------------------
  // driver: byte beats change at the falling edge
  // --------------------------------------------------------------------------
  bit          byte_taken = 1'b0;
  int unsigned send_gap   = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (send_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (serial_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= serial_q.pop_front();
        send_gap      <= sender_steady ? 0 : idle_length();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // byte intake: predictor runs on every accepted byte beat
  always @(posedge clk) begin
    byte_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      absorb_byte(s_axis_tdata);
      bytes_taken <= bytes_taken + 1;
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stalls plus an occasional long hold-off
  // --------------------------------------------------------------------------
  int unsigned hold_ack   = 0;
  int unsigned hold_left  = 0;
  int unsigned stall_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!receiver_steady && $urandom_range(0, 3) == 0) stall_left = idle_length();
    end
  end

  // --------------------------------------------------------------------------
  // monitor: compare each result beat with the oldest expectation
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTED)
        $display("mismatch %0s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTED)
          $display("mismatch: result beat %h with nothing expected", m_axis_tdata);
      end else begin
        want = pending_reports.pop_front();
        check_field("packet_status", 16'(want.status), 16'(m_axis_tdata[2:0]));
        for (int i = 0; i < 6; i++)
          check_field(axis_name[i], want.axes[i], m_axis_tdata[3 + 16 * i +: 16]);
        check_field("button_state", 16'(want.buttons), 16'(m_axis_tdata[110:99]));
        check_field("pad bit", 16'd0, 16'(m_axis_tdata[111]));
      end
    end
  end

  // watchdog: too long with no beat on any channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus building
  // --------------------------------------------------------------------------
  task automatic push_raw(input logic [7:0] b);
    serial_q.push_back(b);
    bytes_queued++;
  endtask

  // one stored packet byte of any value; CR and '^' go in through escapes
  task automatic push_value(input logic [7:0] v);
    logic [7:0] follow;
    if (v == CHAR_CR) begin
      push_raw(CHAR_ESC);
      case ($urandom_range(0, 2))
        0:       push_raw(CHAR_M);
        1:       push_raw(CHAR_Q);
        default: push_raw(CHAR_S);
      endcase
    end else if (v == CHAR_ESC) begin
      // '^' stays stored when the escaped byte is not M, Q or S
      push_raw(CHAR_ESC);
      do follow = 8'($urandom_range(0, 255));
      while (follow == CHAR_M || follow == CHAR_Q || follow == CHAR_S);
      push_raw(follow);
    end else begin
      push_raw(v);
    end
  endtask

  // type byte, random body, terminator: length is body_len + 2
  task automatic push_packet(input logic [7:0] kind, input int unsigned body_len);
    push_value(kind);
    repeat (body_len) push_value(8'($urandom_range(0, 255)));
    push_raw(CHAR_CR);
  endtask

  task automatic push_axes_packet(input logic [5:0][15:0] a);
    push_value(TYPE_AXES);
    push_value(8'($urandom_range(0, 255)));
    push_value(8'($urandom_range(0, 255)));
    for (int i = 0; i < 6; i++) begin
      push_value(a[i][15:8]);
      push_value(a[i][7:0]);
    end
    push_raw(CHAR_CR);
  endtask

  task automatic push_button_packet(input logic [7:0] hi, input logic [7:0] lo);
    push_value(TYPE_BTN);
    push_value(hi);
    push_value(lo);
    push_raw(CHAR_CR);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // mostly well-formed packets with random content, some broken ones and noise
  task automatic random_packet();
    int unsigned      roll;
    logic [5:0][15:0] a;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      for (int i = 0; i < 6; i++) a[i] = pick_axis();
      push_axes_packet(a);
    end else if (roll < 45) begin
      push_button_packet(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else if (roll < 52) begin
      push_packet(TYPE_RESET, $urandom_range(0, 5));
    end else if (roll < 57) begin
      push_packet(TYPE_ERR, $urandom_range(0, 4));
    end else if (roll < 65) begin
      case ($urandom_range(0, 6))
        0:       push_packet(TYPE_K, $urandom_range(0, 6));
        1:       push_packet(TYPE_A, $urandom_range(0, 6));
        2:       push_packet(TYPE_B, $urandom_range(0, 6));
        3:       push_packet(TYPE_H, $urandom_range(0, 6));
        4:       push_packet(TYPE_S, $urandom_range(0, 6));
        5:       push_packet(TYPE_Y, $urandom_range(0, 6));
        default: push_packet(TYPE_QUOTE, $urandom_range(0, 6));
      endcase
    end else if (roll < 71) begin
      push_packet(TYPE_P, $urandom_range(0, 3));
    end else if (roll < 77) begin
      push_packet(8'($urandom_range(0, 255)), $urandom_range(0, 6));
    end else if (roll < 82) begin
      // axes or buttons at a length that is mostly wrong
      push_packet($urandom_range(0, 1) ? TYPE_AXES : TYPE_BTN, $urandom_range(0, 20));
    end else if (roll < 86) begin
      push_raw(CHAR_CR);
    end else if (roll < 87) begin
      push_packet(8'($urandom_range(0, 255)), $urandom_range(MAX_LEN - 2, MAX_LEN + 12));
    end else begin
      // raw noise, may leave a dangling escape or split a packet
      repeat ($urandom_range(1, 6)) push_raw(8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // phase control
  // --------------------------------------------------------------------------
  task automatic wait_for_idle();
    do @(posedge clk);
    while (bytes_taken != bytes_queued || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reports(input logic value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    reports_on = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned goal;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, every packet type, escapes, long packet
    write_reports(1'b1);
    push_axes_packet({16'h8000, 16'h0001, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF});
    push_button_packet(8'hFF, 8'hFF);
    push_button_packet(8'h00, 8'h00);
    // ^M, ^Q or ^S turns a stored '^' into CR; '^' with any other byte keeps the '^'
    push_button_packet(CHAR_CR, CHAR_ESC);
    // escaped CR is data, not a terminator
    push_raw(TYPE_ERR);
    push_raw(CHAR_ESC);
    push_raw(CHAR_CR);
    push_raw(CHAR_CR);
    // type byte rewritten to CR by ^Q
    push_raw(CHAR_ESC);
    push_raw(CHAR_Q);
    push_raw(8'h31);
    push_raw(CHAR_CR);
    push_raw(CHAR_CR);
    push_packet(TYPE_P, 1);
    push_packet(TYPE_P, 2);
    push_packet(TYPE_K, 0);
    push_packet(TYPE_A, 0);
    push_packet(TYPE_B, 0);
    push_packet(TYPE_H, 0);
    push_packet(TYPE_S, 0);
    push_packet(TYPE_Y, 0);
    push_packet(TYPE_QUOTE, 0);
    push_packet(8'h7A, 1);
    // '^' past the kept bytes: ^S leaves the packet alone
    push_value(TYPE_AXES);
    repeat (20) push_raw(8'h20);
    push_raw(CHAR_ESC);
    push_raw(CHAR_S);
    push_raw(CHAR_CR);
    // long packet: '^' past the saturated count is not stored
    push_value(TYPE_RESET);
    repeat (MAX_LEN) push_raw(8'h41);
    push_raw(CHAR_ESC);
    push_raw(CHAR_M);
    push_raw(CHAR_CR);
    push_axes_packet({16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0F0F, 16'hF0F0});
    push_packet(TYPE_RESET, 0);
    wait_for_idle();

    // reports off: axes and buttons refused, clear still works
    write_reports(1'b0);
    push_axes_packet({16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF});
    push_button_packet(8'hFF, 8'hFF);
    wait_for_idle();
    write_reports(1'b1);
    push_axes_packet({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    push_button_packet(8'hFF, 8'hFF);
    wait_for_idle();
    write_reports(1'b0);
    push_packet(TYPE_RESET, 2);
    wait_for_idle();

    // back-pressure: result side held off while terminators keep coming
    write_reports(1'b1);
    sender_steady = 1'b1;
    hold_req++;
    repeat (12) push_packet(TYPE_ERR, 0);
    push_button_packet(8'h5A, 8'hA5);
    wait_for_idle();
    sender_steady = 1'b0;

    // random phases across both settings, some without any idling
    for (int p = 0; p < 6; p++) begin
      write_reports((p == 1 || p == 4) ? 1'b0 : 1'b1);
      sender_steady   = (p == 2);
      receiver_steady = (p == 3);
      goal = bytes_queued + 70;
      while (bytes_queued < goal) random_packet();
      wait_for_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
